/* design/group_min_sum_sorted_report_unit_assert.svh */
// ----------------------------------------------------------------------------
// group_min_sum_sorted_report_unit_assert.svh
// assertion macros shared by the group aggregate block
// ----------------------------------------------------------------------------
`ifndef GROUP_MIN_SUM_SORTED_REPORT_UNIT_ASSERT_SVH
`define GROUP_MIN_SUM_SORTED_REPORT_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define GMSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define GMSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/gmsr_pkg.sv */
// ----------------------------------------------------------------------------
// gmsr_pkg
// shared types and constants for the group aggregate and sorted report block
// ----------------------------------------------------------------------------
package gmsr_pkg;

  localparam int KEY_HI_W = 64;
  localparam int KEY_LO_W = 40;
  localparam int VAL_W    = 24;
  localparam int TOT_W    = 30;
  localparam int CNT_W    = 5;
  localparam int ORD_W    = TOT_W + KEY_HI_W + KEY_LO_W;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  // one table entry
  typedef struct packed {
    logic [KEY_HI_W-1:0] kh;
    logic [KEY_LO_W-1:0] kl;
    logic [VAL_W-1:0]    mn;
    logic [TOT_W-1:0]    tot;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic cap_in;
    logic rd_en;
    logic wr_upd;
    logic wr_new;
    logic scan_start;
    logic scan_chk;
    logic load_out;
    logic report_clr;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic match;
  } sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_INSERT,
    S_SCAN,
    S_EMIT
  } state_t;

  // report order: ascending total, then ascending key
  function automatic logic [ORD_W-1:0] order_key(entry_t e);
    return {e.tot, e.kh, e.kl};
  endfunction

endpackage

/* design/group_min_sum_sorted_report_unit.sv */
// ----------------------------------------------------------------------------
// group_min_sum_sorted_report_unit
// group-by aggregate of minimum and saturating sum with a sorted report
// ----------------------------------------------------------------------------
// Records enter on the in_ stream: key and value in in_tdata, in_tlast marks
// the final record of a batch. Each record is matched against the group
// table one entry per cycle through the table's single read port, up to the
// first match, then written back in an update or insert step before the next
// record is taken. A record whose key is new opens a group; when the
// table is full it is dropped and the overflow flag is set.
// After the record marked in_tlast is absorbed, one result per group leaves
// on the out_ stream in ascending sum order, equal sums by ascending key.
// Each result is found by a full scan of the table and offered from the
// output register; the next scan starts once the receiver has taken it.
// out_tlast marks the final group; the table then empties for the next batch.
// No record is taken while a report runs. A stalled receiver holds the
// current result steady in the output register. Reset empties the table and
// clears the overflow flag; stored entries need no clearing.
// ----------------------------------------------------------------------------
module group_min_sum_sorted_report_unit #(
  parameter int MAX_GROUPS = 16,
  parameter int VALUE_BITS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // key_high[63:0], key_low[103:64], item_value[127:104]
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata,  // out_key_high[63:0], out_key_low[103:64],
                                   // smallest_value[127:104], value_total[157:128],
                                   // group_count[162:158], zero fill above
  output logic         out_tuser,  // table_overflow
  output logic         out_tlast
);
  import gmsr_pkg::*;

  localparam int IW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW = $clog2(MAX_GROUPS + 1);

  cmd_t              cmd;
  sts_t              sts;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     wr_addr;
  logic [CNT_W-1:0]  group_count;
  logic              overflow;
  logic              last_group;
  entry_t            out_ent;

  // sequencer
  gmsr_ctrl #(
    .MAX_GROUPS (MAX_GROUPS),
    .IW         (IW),
    .CW         (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cmd         (cmd),
    .sts         (sts),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .group_count (group_count),
    .overflow    (overflow),
    .last_group  (last_group)
  );

  // table and compare datapath
  gmsr_dpath #(
    .MAX_GROUPS (MAX_GROUPS),
    .VALUE_BITS (VALUE_BITS),
    .IW         (IW)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .in_kh   (in_tdata[63:0]),
    .in_kl   (in_tdata[103:64]),
    .in_val  (in_tdata[127:104]),
    .out_ent (out_ent)
  );

  // result packing
  assign out_tdata = {5'b0, group_count, out_ent.tot, out_ent.mn, out_ent.kl, out_ent.kh};
  assign out_tuser = overflow;
  assign out_tlast = last_group;

  `include "group_min_sum_sorted_report_unit_assert.svh"

  `GMSR_ASSERT_NOW(a_one_side, in_tready, !out_tvalid, "input open while result held")
  `GMSR_ASSERT_NEXT(a_end_idle, out_tvalid && out_tready && out_tlast, in_tready,
    "not idle after final result")
  `GMSR_ASSERT_NOW(a_one_write, cmd.wr_upd, !cmd.wr_new, "update and insert together")

endmodule

/* design/gmsr_dpath.sv */
// ----------------------------------------------------------------------------
// gmsr_dpath
// group table memory, key compare, min/sum update and report selection
// ----------------------------------------------------------------------------
module gmsr_dpath #(
  parameter int MAX_GROUPS = 16,
  parameter int VALUE_BITS = 24,
  parameter int IW = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gmsr_pkg::cmd_t                    cmd,
  output gmsr_pkg::sts_t                    sts,
  input  logic [IW-1:0]                     rd_addr,
  input  logic [IW-1:0]                     wr_addr,
  input  logic [gmsr_pkg::KEY_HI_W-1:0]     in_kh,
  input  logic [gmsr_pkg::KEY_LO_W-1:0]     in_kl,
  input  logic [gmsr_pkg::VAL_W-1:0]        in_val,
  output gmsr_pkg::entry_t                  out_ent
);
  import gmsr_pkg::*;

  localparam int VW = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam logic [VAL_W-1:0] VMASK = {VAL_W{1'b1}} >> (VAL_W - VW);

  entry_t              mem [MAX_GROUPS];
  entry_t              rd_q_r;
  logic [KEY_HI_W-1:0] kh_r;
  logic [KEY_LO_W-1:0] kl_r;
  logic [VAL_W-1:0]    v_r;
  entry_t              best_r;
  logic                best_v_r;
  entry_t              last_r;
  logic                have_last_r;
  entry_t              out_r;
  entry_t              upd_ent;
  entry_t              new_ent;
  entry_t              wdata;
  entry_t              sel_ent;
  logic [TOT_W:0]      sum;
  logic                take;

  // captured record
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      kh_r <= in_kh;
      kl_r <= in_kl;
      v_r  <= in_val & VMASK;
    end
  end

  // key match against the entry just read
  assign sts.match = (rd_q_r.kh == kh_r) && (rd_q_r.kl == kl_r);

  // entry update and new entry
  always_comb begin
    sum        = {1'b0, rd_q_r.tot} + (TOT_W+1)'(v_r);
    upd_ent.kh = rd_q_r.kh;
    upd_ent.kl = rd_q_r.kl;
    upd_ent.mn = (v_r < rd_q_r.mn) ? v_r : rd_q_r.mn;
    upd_ent.tot = sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
    new_ent.kh = kh_r;
    new_ent.kl = kl_r;
    new_ent.mn = v_r;
    new_ent.tot = TOT_W'(v_r);
    wdata      = cmd.wr_upd ? upd_ent : new_ent;
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_upd || cmd.wr_new) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // smallest entry above the last one reported
  assign take = cmd.scan_chk
              && (!have_last_r || (order_key(rd_q_r) > order_key(last_r)))
              && (!best_v_r || (order_key(rd_q_r) < order_key(best_r)));
  assign sel_ent = take ? rd_q_r : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_v_r    <= 1'b0;
      have_last_r <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        best_v_r <= 1'b0;
      end else if (take) begin
        best_v_r <= 1'b1;
      end
      if (cmd.report_clr) begin
        have_last_r <= 1'b0;
      end else if (cmd.load_out) begin
        have_last_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_r <= rd_q_r;
    end
    if (cmd.load_out) begin
      last_r <= sel_ent;
      out_r  <= sel_ent;
    end
  end

  assign out_ent = out_r;

endmodule

/* design/gmsr_ctrl.sv */
// ----------------------------------------------------------------------------
// gmsr_ctrl
// sequencer for table search, update, insert and sorted report
// ----------------------------------------------------------------------------
module gmsr_ctrl #(
  parameter int MAX_GROUPS = 16,
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output gmsr_pkg::cmd_t            cmd,
  input  gmsr_pkg::sts_t            sts,
  output logic [IW-1:0]             rd_addr,
  output logic [IW-1:0]             wr_addr,
  output logic [gmsr_pkg::CNT_W-1:0] group_count,
  output logic                      overflow,
  output logic                      last_group
);
  import gmsr_pkg::*;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [IW-1:0]   chk_r, chk_nxt;
  logic            chk_v_r, chk_v_nxt;
  logic [CW-1:0]   used_r, used_nxt;
  logic            ovf_r, ovf_nxt;
  logic            lastp_r, lastp_nxt;
  logic [CW-1:0]   rank_r, rank_nxt;
  logic            chk_end;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      chk_r   <= '0;
      chk_v_r <= 1'b0;
      used_r  <= '0;
      ovf_r   <= 1'b0;
      lastp_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      chk_r   <= chk_nxt;
      chk_v_r <= chk_v_nxt;
      used_r  <= used_nxt;
      ovf_r   <= ovf_nxt;
      lastp_r <= lastp_nxt;
      rank_r  <= rank_nxt;
    end
  end

  assign chk_end = chk_v_r && (CW'(chk_r) == used_r - CW'(1));

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    chk_nxt    = chk_r;
    chk_v_nxt  = chk_v_r;
    used_nxt   = used_r;
    ovf_nxt    = ovf_r;
    lastp_nxt  = lastp_r;
    rank_nxt   = rank_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    rd_addr    = idx_r[IW-1:0];
    wr_addr    = (state_r == S_UPDATE) ? chk_r : used_r[IW-1:0];

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap_in = 1'b1;
          lastp_nxt  = in_tlast;
          idx_nxt    = '0;
          chk_v_nxt  = 1'b0;
          state_nxt  = (used_r == '0) ? S_INSERT : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (chk_v_r && sts.match) begin
          chk_v_nxt = 1'b0;
          state_nxt = S_UPDATE;
        end else if (chk_end) begin
          chk_v_nxt = 1'b0;
          state_nxt = S_INSERT;
        end else if (idx_r < used_r) begin
          cmd.rd_en = 1'b1;
          chk_nxt   = idx_r[IW-1:0];
          chk_v_nxt = 1'b1;
          idx_nxt   = idx_r + CW'(1);
        end else begin
          chk_v_nxt = 1'b0;
        end
      end
      S_UPDATE, S_INSERT: begin
        if (state_r == S_UPDATE) begin
          cmd.wr_upd = 1'b1;
        end else if (used_r == CW'(MAX_GROUPS)) begin
          ovf_nxt = 1'b1;
        end else begin
          cmd.wr_new = 1'b1;
          used_nxt   = used_r + CW'(1);
        end
        if (lastp_r) begin
          cmd.scan_start = 1'b1;
          rank_nxt  = '0;
          idx_nxt   = '0;
          chk_v_nxt = 1'b0;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_chk = chk_v_r;
        if (chk_end) begin
          cmd.load_out = 1'b1;
          chk_v_nxt    = 1'b0;
          state_nxt    = S_EMIT;
        end else if (idx_r < used_r) begin
          cmd.rd_en = 1'b1;
          chk_nxt   = idx_r[IW-1:0];
          chk_v_nxt = 1'b1;
          idx_nxt   = idx_r + CW'(1);
        end else begin
          chk_v_nxt = 1'b0;
        end
      end
      S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (rank_r == used_r - CW'(1)) begin
            cmd.report_clr = 1'b1;
            used_nxt  = '0;
            ovf_nxt   = 1'b0;
            lastp_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            rank_nxt  = rank_r + CW'(1);
            idx_nxt   = '0;
            chk_v_nxt = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // report side fields, steady while a result is held
  assign group_count = CNT_W'(used_r);
  assign overflow    = ovf_r;
  assign last_group  = (rank_r == used_r - CW'(1));

endmodule

/* verif/group_min_sum_sorted_report_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// group_min_sum_sorted_report_unit_tb
// self-checking bench for the group aggregate and sorted report block
// ----------------------------------------------------------------------------
// Records are streamed in batches; a software copy of the group table tracks
// minimum and saturating sum per key and, on the final record, builds the
// sorted report that the block must return. Batches cover duplicate keys,
// full tables with dropped groups, sum saturation, ties broken by key and
// random traffic, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module group_min_sum_sorted_report_unit_tb;
  import gmsr_pkg::*;

  localparam int NGRP = 16;
  localparam int WDOG = 20000;

  typedef struct packed {
    logic [KEY_HI_W-1:0] kh;
    logic [KEY_LO_W-1:0] kl;
    logic [VAL_W-1:0]    mn;
    logic [TOT_W-1:0]    tot;
    logic [CNT_W-1:0]    cnt;
    logic                ovf;
    logic                lst;
  } report_t;

  // group table model and report queue
  class group_report_board;
    entry_t    tbl[NGRP];
    int        used;
    bit        ovf;
    report_t   pending[$];
    int        errors;

    function void note_record(logic [63:0] kh, logic [39:0] kl, logic [23:0] v, bit lst);
      int i, j, hit;
      logic [31:0] t;
      entry_t tmp;
      report_t r;
      entry_t srt[NGRP];
      hit = 0;
      for (i = 0; i < used; i++) begin
        if (!hit && tbl[i].kh == kh && tbl[i].kl == kl) begin
          hit = 1;
          if (v < tbl[i].mn) tbl[i].mn = v;
          t = 32'(tbl[i].tot) + 32'(v);
          tbl[i].tot = (t > 32'(TOT_MAX)) ? TOT_MAX : t[TOT_W-1:0];
        end
      end
      if (!hit) begin
        if (used >= NGRP) ovf = 1;
        else begin
          tbl[used] = '{kh: kh, kl: kl, mn: v, tot: TOT_W'(v)};
          used++;
        end
      end
      if (!lst) return;
      for (i = 0; i < used; i++) srt[i] = tbl[i];
      // insertion sort on total, then key
      for (i = 1; i < used; i++) begin
        tmp = srt[i];
        j = i;
        while (j > 0 && {tmp.tot, tmp.kh, tmp.kl} < {srt[j-1].tot, srt[j-1].kh, srt[j-1].kl})
        begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = tmp;
      end
      for (i = 0; i < used; i++) begin
        r = '{kh: srt[i].kh, kl: srt[i].kl, mn: srt[i].mn, tot: srt[i].tot,
              cnt: used[CNT_W-1:0], ovf: ovf, lst: (i == used - 1)};
        pending.insert(pending.size(), r);
      end
      used = 0;
      ovf = 0;
    endfunction

    function void check_group(report_t got);
      report_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected group result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10) $display("group mismatch: expected %h actual %h", e, got);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [167:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  group_report_board board = new();
  int  idle_cycles;
  bit  hold_off;
  bit  stall_done;

  group_min_sum_sorted_report_unit dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // key pool so random batches hit existing groups often
  logic [63:0] pool_kh[24];
  logic [39:0] pool_kl[24];

  task automatic send_record(logic [63:0] kh, logic [39:0] kl, logic [23:0] v, bit lst);
    in_tvalid <= 1;
    in_tdata  <= {v, kl, kh};
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    board.note_record(kh, kl, v, lst);
    // random gap between bursts
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // batch of n records drawn from a pool of np keys
  task automatic send_batch(int n, int np, int vmode);
    int k;
    logic [23:0] v;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, np - 1);
      case (vmode)
        0: v = 24'($urandom);
        1: v = 24'hFFFFFF - 24'($urandom_range(0, 3));
        default: v = 24'($urandom_range(0, 7));
      endcase
      send_record(pool_kh[k], pool_kl[k], v, i == n - 1);
    end
  endtask

  // result capture
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_group('{kh: out_tdata[63:0], kl: out_tdata[103:64],
                          mn: out_tdata[127:104], tot: out_tdata[157:128],
                          cnt: out_tdata[162:158], ovf: out_tuser, lst: out_tlast});
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (hold_off) out_tready <= 0;
    else out_tready <= ($urandom_range(0, 2) != 0) || (($urandom & 63) < 8);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int sent;
    idle_cycles = 0;
    hold_off = 0;
    for (int i = 0; i < 24; i++) begin
      pool_kh[i] = {$urandom, $urandom};
      pool_kl[i] = 40'({$urandom, $urandom});
    end
    // extremes in the pool
    pool_kh[0] = '0;  pool_kl[0] = '0;
    pool_kh[1] = '1;  pool_kl[1] = '1;
    pool_kh[2] = '0;  pool_kl[2] = '1;
    pool_kh[3] = '1;  pool_kl[3] = '0;
    pool_kh[4] = 64'h0000_0000_0000_0001; pool_kl[4] = 40'h80_0000_0000;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // single record batch, extreme fields
    send_record('1, '1, '1, 1);
    send_record('0, '0, '0, 1);
    // equal sums ordered by key
    send_record(pool_kh[1], pool_kl[1], 24'd5, 0);
    send_record(pool_kh[0], pool_kl[0], 24'd5, 0);
    send_record(pool_kh[2], pool_kl[2], 24'd5, 0);
    send_record(pool_kh[4], pool_kl[4], 24'd9, 0);
    send_record(pool_kh[4], pool_kl[4], 24'd2, 1);
    // saturation
    for (int i = 0; i < 70; i++) send_record(pool_kh[3], pool_kl[3], '1, i == 69);
    wait_drained();
    // table full with dropped groups
    for (int i = 0; i < 18; i++) send_record(pool_kh[i], pool_kl[i], 24'(i), i == 17);
    wait_drained();
    sent = 0;

    // long receiver hold-off: a short batch starts a report that stalls,
    // while the next batch keeps offering items against the blocked input
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      begin
        send_batch(4, 4, 0);
        send_batch(30, 20, 0);
      end
    join
    wait_drained();

    while (sent < 300) begin
      int n;
      n = $urandom_range(1, 20);
      case ($urandom_range(0, 3))
        0: send_batch(n, 24, 0);
        1: send_batch(n, 4, 1);
        2: send_batch(n, 6, 2);
        default: send_batch(n, 12, 0);
      endcase
      sent += n;
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    wait_drained();
    repeat (400) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
